FILE: design/twist_gyro_mean_fuser_macros.svh
// Assertion helpers for the twist gyro mean fuser.
`ifndef TWIST_GYRO_MEAN_FUSER_MACROS_SVH
`define TWIST_GYRO_MEAN_FUSER_MACROS_SVH
`ifndef SYNTHESIS
`define TGMF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tgmf assertion failed");
`define TGMF_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("tgmf forbidden condition");
`else
`define TGMF_ASSERT(name, clk, rstn, prop)
`define TGMF_NEVER(name, clk, rstn, cond)
`endif
`endif

FILE: design/tgmf_pkg.sv
package tgmf_pkg;

  localparam int STAMP_W    = 63;
  localparam int DATA_W     = 32;
  localparam int TIMEOUT_W  = 34;
  localparam int THRESH_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 34;
  localparam int NUM_RES    = 8;
  localparam int RES_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'b1;

  localparam logic OP_SPEED = 1'b0;
  localparam logic OP_GYRO  = 1'b1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 34'd200000000;

  // Result slots in division order
  localparam logic [RES_IDX_W-1:0] RES_SPEED   = 3'd0;
  localparam logic [RES_IDX_W-1:0] RES_RATE_X  = 3'd1;
  localparam logic [RES_IDX_W-1:0] RES_RATE_Y  = 3'd2;
  localparam logic [RES_IDX_W-1:0] RES_RATE_Z  = 3'd3;
  localparam logic [RES_IDX_W-1:0] RES_SPD_VAR = 3'd4;
  localparam logic [RES_IDX_W-1:0] RES_X_VAR   = 3'd5;
  localparam logic [RES_IDX_W-1:0] RES_Y_VAR   = 3'd6;
  localparam logic [RES_IDX_W-1:0] RES_Z_VAR   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_FIN
  } state_e;

endpackage

FILE: design/twist_gyro_mean_fuser.sv
// An item is accepted in idle and then goes through the freshness check.
// An item that yields a result then runs eight divisions, one quotient bit
// per cycle on the single shared restoring divider, each between a load and a
// store step, then waits in the finish state for a free output register.
// The next item is taken once the sequencer is back in idle.
// Reset clears flags, stamps, sums and counts and loads the register defaults.
`include "twist_gyro_mean_fuser_macros.svh"
module twist_gyro_mean_fuser
  import tgmf_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [STAMP_W-1:0]       stamp_ns_i,
  input  logic signed [DATA_W-1:0] speed_i,
  input  logic [DATA_W-1:0]        speed_var_i,
  input  logic signed [DATA_W-1:0] rate_x_i,
  input  logic signed [DATA_W-1:0] rate_y_i,
  input  logic signed [DATA_W-1:0] rate_z_i,
  input  logic [DATA_W-1:0]        rate_x_var_i,
  input  logic [DATA_W-1:0]        rate_y_var_i,
  input  logic [DATA_W-1:0]        rate_z_var_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAMP_W-1:0]       out_stamp_ns_o,
  output logic signed [DATA_W-1:0] mean_speed_o,
  output logic signed [DATA_W-1:0] mean_rate_x_o,
  output logic signed [DATA_W-1:0] mean_rate_y_o,
  output logic signed [DATA_W-1:0] mean_rate_z_o,
  output logic [DATA_W-1:0]        fused_speed_var_o,
  output logic [DATA_W-1:0]        fused_rate_x_var_o,
  output logic [DATA_W-1:0]        fused_rate_y_var_o,
  output logic [DATA_W-1:0]        fused_rate_z_var_o,
  output logic                     stopped_o
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = DATA_W + $clog2(MAX_SAMPLES);
  localparam int DEN_W = 2 * CNT_W;
  localparam int BIT_W = $clog2(SUM_W);
  localparam logic [63:0] THRESH_FULL = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_FULL[THRESH_W-1:0];
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(SUM_W - 1);

  state_e state_q, state_d;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [THRESH_W-1:0]  thresh_q;

  logic                 spd_seen_q, gyro_seen_q;
  logic [STAMP_W-1:0]   spd_stamp_q, gyro_stamp_q;
  logic [CNT_W-1:0]     spd_cnt_q, gyro_cnt_q;
  logic signed [SUM_W-1:0] spd_sum_q;
  logic [SUM_W-1:0]     spd_var_sum_q;
  logic signed [SUM_W-1:0] rate_sum_q [3];
  logic [SUM_W-1:0]     rate_var_sum_q [3];

  logic [RES_IDX_W-1:0] idx_q;
  logic [BIT_W-1:0]     bit_q;
  logic [SUM_W-1:0]     quo_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic                 neg_q;
  logic [DATA_W-1:0]    res_q [NUM_RES];
  logic                 spd_small_q, yaw_small_q;
  logic                 out_valid_q;

  logic acc_en, clr_en, load_en, step_en, store_en, fin_en;
  logic in_xfer;

  // Freshness check
  logic [STAMP_W-1:0] newer, age;
  logic               stale;

  always_comb begin
    if (spd_stamp_q > gyro_stamp_q) begin
      newer = spd_stamp_q;
      age   = spd_stamp_q - gyro_stamp_q;
    end else begin
      newer = gyro_stamp_q;
      age   = gyro_stamp_q - spd_stamp_q;
    end
    stale = age > STAMP_W'(timeout_q);
  end

  // Divider operand select
  logic signed [SUM_W-1:0] sel_s;
  logic [SUM_W-1:0]        sel_u;
  logic                    sel_var;
  logic [DEN_W-1:0]        sel_den;
  logic [DEN_W-1:0]        spd_sq, gyro_sq;

  assign spd_sq  = DEN_W'(spd_cnt_q) * DEN_W'(spd_cnt_q);
  assign gyro_sq = DEN_W'(gyro_cnt_q) * DEN_W'(gyro_cnt_q);

  always_comb begin
    sel_s   = spd_sum_q;
    sel_u   = spd_var_sum_q;
    sel_var = 1'b0;
    sel_den = DEN_W'(spd_cnt_q);
    case (idx_q)
      RES_SPEED:   begin sel_s = spd_sum_q;     sel_den = DEN_W'(spd_cnt_q); end
      RES_RATE_X:  begin sel_s = rate_sum_q[0]; sel_den = DEN_W'(gyro_cnt_q); end
      RES_RATE_Y:  begin sel_s = rate_sum_q[1]; sel_den = DEN_W'(gyro_cnt_q); end
      RES_RATE_Z:  begin sel_s = rate_sum_q[2]; sel_den = DEN_W'(gyro_cnt_q); end
      RES_SPD_VAR: begin sel_u = spd_var_sum_q;     sel_var = 1'b1; sel_den = spd_sq; end
      RES_X_VAR:   begin sel_u = rate_var_sum_q[0]; sel_var = 1'b1; sel_den = gyro_sq; end
      RES_Y_VAR:   begin sel_u = rate_var_sum_q[1]; sel_var = 1'b1; sel_den = gyro_sq; end
      RES_Z_VAR:   begin sel_u = rate_var_sum_q[2]; sel_var = 1'b1; sel_den = gyro_sq; end
      default:     begin sel_s = spd_sum_q; end
    endcase
  end

  // Restoring divider step
  logic [DEN_W:0]     shifted, trial;
  logic               ge;
  logic [SUM_W-1:0]   quo_signed;

  assign shifted    = {rem_q, quo_q[SUM_W-1]};
  assign trial      = shifted - {1'b0, den_q};
  assign ge         = shifted >= {1'b0, den_q};
  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  assign in_xfer = in_valid_i && !in_stall_o;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    acc_en     = 1'b0;
    clr_en     = 1'b0;
    load_en    = 1'b0;
    step_en    = 1'b0;
    store_en   = 1'b0;
    fin_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          acc_en  = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!spd_seen_q || !gyro_seen_q || stale) begin
          clr_en  = 1'b1;
          state_d = ST_IDLE;
        end else if (spd_cnt_q == '0 || gyro_cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load_en = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step_en = 1'b1;
        if (bit_q == '0) state_d = ST_STORE;
      end
      ST_STORE: begin
        store_en = 1'b1;
        state_d  = (idx_q == RES_Z_VAR) ? ST_FIN : ST_LOAD;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          fin_en  = 1'b1;
          clr_en  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      thresh_q  <= THRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TIMEOUT: timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        REG_THRESH:  thresh_q  <= cfg_data_i[THRESH_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_seen_q     <= 1'b0;
      gyro_seen_q    <= 1'b0;
      spd_stamp_q    <= '0;
      gyro_stamp_q   <= '0;
      spd_cnt_q      <= '0;
      gyro_cnt_q     <= '0;
      spd_sum_q      <= '0;
      spd_var_sum_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        rate_sum_q[i]     <= '0;
        rate_var_sum_q[i] <= '0;
      end
    end else if (clr_en) begin
      spd_cnt_q     <= '0;
      gyro_cnt_q    <= '0;
      spd_sum_q     <= '0;
      spd_var_sum_q <= '0;
      for (int i = 0; i < 3; i++) begin
        rate_sum_q[i]     <= '0;
        rate_var_sum_q[i] <= '0;
      end
    end else if (acc_en) begin
      if (opcode_i == OP_SPEED) begin
        spd_seen_q  <= 1'b1;
        spd_stamp_q <= stamp_ns_i;
        if (spd_cnt_q < CNT_MAX) begin
          spd_sum_q     <= spd_sum_q + SUM_W'(speed_i);
          spd_var_sum_q <= spd_var_sum_q + SUM_W'(speed_var_i);
          spd_cnt_q     <= spd_cnt_q + CNT_W'(1);
        end
      end else begin
        gyro_seen_q  <= 1'b1;
        gyro_stamp_q <= stamp_ns_i;
        // drop samples once the side is full
        if (gyro_cnt_q < CNT_MAX) begin
          rate_sum_q[0]     <= rate_sum_q[0] + SUM_W'(rate_x_i);
          rate_sum_q[1]     <= rate_sum_q[1] + SUM_W'(rate_y_i);
          rate_sum_q[2]     <= rate_sum_q[2] + SUM_W'(rate_z_i);
          rate_var_sum_q[0] <= rate_var_sum_q[0] + SUM_W'(rate_x_var_i);
          rate_var_sum_q[1] <= rate_var_sum_q[1] + SUM_W'(rate_y_var_i);
          rate_var_sum_q[2] <= rate_var_sum_q[2] + SUM_W'(rate_z_var_i);
          gyro_cnt_q        <= gyro_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      bit_q <= '0;
    end else begin
      if (acc_en) idx_q <= RES_SPEED;
      else if (store_en) idx_q <= idx_q + RES_IDX_W'(1);
      if (load_en) bit_q <= BIT_LAST;
      else if (step_en) bit_q <= bit_q - BIT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      rem_q <= '0;
      den_q <= sel_den;
      if (sel_var) begin
        quo_q <= sel_u;
        neg_q <= 1'b0;
      end else begin
        quo_q <= sel_s[SUM_W-1] ? SUM_W'(-sel_s) : SUM_W'(sel_s);
        neg_q <= sel_s[SUM_W-1];
      end
    end else if (step_en) begin
      if (ge) begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DEN_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
    if (store_en) begin
      res_q[idx_q] <= quo_signed[DATA_W-1:0];
      if (idx_q == RES_SPEED)  spd_small_q <= quo_q < SUM_W'(thresh_q);
      if (idx_q == RES_RATE_Z) yaw_small_q <= quo_q < SUM_W'(thresh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (fin_en) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_stamp_ns_o     <= newer;
      mean_speed_o       <= res_q[RES_SPEED];
      mean_rate_x_o      <= res_q[RES_RATE_X];
      mean_rate_y_o      <= res_q[RES_RATE_Y];
      mean_rate_z_o      <= res_q[RES_RATE_Z];
      fused_speed_var_o  <= res_q[RES_SPD_VAR];
      fused_rate_x_var_o <= res_q[RES_X_VAR];
      fused_rate_y_var_o <= res_q[RES_Y_VAR];
      fused_rate_z_var_o <= res_q[RES_Z_VAR];
      stopped_o          <= spd_small_q && yaw_small_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `TGMF_ASSERT(a_rise_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  `TGMF_NEVER(a_cnt_bound, clk_i, rst_ni, spd_cnt_q > CNT_MAX || gyro_cnt_q > CNT_MAX)
  `TGMF_ASSERT(a_fin_clears, clk_i, rst_ni, $past(fin_en) |-> spd_cnt_q == '0 && gyro_cnt_q == '0)
  `TGMF_NEVER(a_accept_busy, clk_i, rst_ni, in_xfer && state_q != ST_IDLE)

endmodule
